// ===== rtl/drt_pkg.sv =====
// Shared types and constants for the device key range table.
// Holds table sizing, status codes, the FSM state type and the control/status structs.
// No dependencies.
`default_nettype none

package drt_pkg;

    // Table sizing
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int MAX_W = 5;
    localparam int LIM_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 5'd16;

    // Request type codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_OVERLAP   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [15:0] start;
        logic [7:0]  count;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_req;
        logic    clr_idx;
        logic    issue;
        logic    set_res;
        status_t res_status;
        logic    res_found;
        logic    wr_entry;
        logic    load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_lookup;
        logic add_invalid;
        logic add_full;
        logic scan_more;
        logic cmp_pending;
        logic cmp_hit;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/device_key_range_table.sv =====
// Device key range table: stores 128-bit keys, each owning an address range.
//
// Requests arrive on in_valid/in_ready: req_type selects an add (address is the
// range start, element_count its length, key_low/key_high the key) or a lookup
// (address is the queried address). Each request gives exactly one result on
// out_valid/out_ready: status plus the matching key, start and count on a lookup hit.
// max_entries is to be written by the user through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
//
// Timing: a request is taken in idle, checked in S_CHECK, then the stored
// entries are scanned one per cycle from the entry memory's single read port.
// An add rejected as invalid or full goes from S_CHECK straight to S_DONE
// without a scan. The next request is taken in the cycle after the result moves
// into the output register, so only one request is in flight at a time.
// The output register holds a result while the receiver stalls; a further
// request is then processed but its result waits until the register frees.
// Reset empties the table (fill count 0) and sets max_entries to 16.
// Dependencies: drt_pkg, drt_ctrl, drt_dpath.
`default_nettype none

module device_key_range_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [15:0]               address,
    input  logic [7:0]                element_count,
    input  logic [63:0]               key_low,
    input  logic [63:0]               key_high,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                status,
    output logic [63:0]               found_key_low,
    output logic [63:0]               found_key_high,
    output logic [15:0]               found_start,
    output logic [7:0]                found_count,
    input  logic                      cfg_wr_en,
    input  logic [drt_pkg::MAX_W-1:0] cfg_wr_data
);
    import drt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    drt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    drt_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .address        (address),
        .element_count  (element_count),
        .key_low        (key_low),
        .key_high       (key_high),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_key_low  (found_key_low),
        .found_key_high (found_key_high),
        .found_start    (found_start),
        .found_count    (found_count)
    );

    // Only one request in flight
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // Never append past the table limit
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_entry |-> (!stat.add_full && !stat.is_lookup))
        else $error("entry appended while table full");

    // Reads stay inside the filled part of the table
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> stat.scan_more)
        else $error("scan read beyond fill count");

    // Output register is loaded only when free
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result overwrote a waiting result");

endmodule

`default_nettype wire

// ===== rtl/drt_ctrl.sv =====
// Controller FSM for the device key range table.
// Sequences check, table scan and result hand-off; depends on drt_pkg.
`default_nettype none

module drt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  drt_pkg::stat_t stat,
    output drt_pkg::cmd_t  cmd
);
    import drt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.is_lookup && (stat.add_invalid || stat.add_full))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.cmp_hit || (!stat.scan_more && !stat.cmp_pending))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_CHECK:
            begin
                if (!stat.is_lookup && stat.add_invalid)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_INVALID;
                end
                else if (!stat.is_lookup && stat.add_full)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_FULL;
                end
                else
                begin
                    cmd.clr_idx = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.cmp_hit)
                begin
                    // first match wins: found entry for lookup, conflict for add
                    cmd.set_res = 1'b1;
                    if (stat.is_lookup)
                    begin
                        cmd.res_status = ST_OK;
                        cmd.res_found  = 1'b1;
                    end
                    else
                    begin
                        cmd.res_status = ST_OVERLAP;
                    end
                end
                else if (stat.scan_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!stat.cmp_pending)
                begin
                    // scan exhausted without a match
                    cmd.set_res = 1'b1;
                    if (stat.is_lookup)
                    begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.res_status = ST_OK;
                        cmd.wr_entry   = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/drt_dpath.sv =====
// Datapath for the device key range table: request registers, entry memory,
// range compare, fill counter, limit register and output register; depends on drt_pkg.
`default_nettype none

module drt_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  drt_pkg::cmd_t              cmd,
    output drt_pkg::stat_t             stat,
    input  logic                       req_type,
    input  logic [15:0]                address,
    input  logic [7:0]                 element_count,
    input  logic [63:0]                key_low,
    input  logic [63:0]                key_high,
    input  logic                       cfg_wr_en,
    input  logic [drt_pkg::MAX_W-1:0]  cfg_wr_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 status,
    output logic [63:0]                found_key_low,
    output logic [63:0]                found_key_high,
    output logic [15:0]                found_start,
    output logic [7:0]                 found_count
);
    import drt_pkg::*;

    // Request registers
    logic        req_type_reg;
    logic [15:0] addr_reg;
    logic [7:0]  count_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;

    // Control counters
    logic [MAX_W-1:0] max_entries_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             cmp_valid_reg;

    // Entry memory and read port
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // Result and output registers
    status_t     res_status_reg;
    entry_t      res_entry_reg;
    logic        out_valid_reg;
    status_t     out_status_reg;
    entry_t      out_entry_reg;

    logic [16:0] ent_end;
    logic [16:0] new_end;
    logic        lookup_hit;
    logic        overlap_hit;

    // Capture request
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            addr_reg     <= address;
            count_reg    <= element_count;
            key_low_reg  <= key_low;
            key_high_reg <= key_high;
        end
    end

    // Write limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else if (cfg_wr_en)
        begin
            max_entries_reg <= cfg_wr_data;
        end
    end

    // Advance fill count and scan index
    always_comb
    begin
        used_next = used_reg;
        if (cmd.wr_entry)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmd.issue;
        end
    end

    // Append entry at the fill position
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            mem[used_reg[IDX_W-1:0]] <= '{key_high: key_high_reg, key_low: key_low_reg,
                                          start: addr_reg, count: count_reg};
        end
    end

    // Read entry at the scan index
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Compare the fetched range against the request; ends never wrap in 17 bits
    assign ent_end = {1'b0, rd_data_reg.start} + {9'd0, rd_data_reg.count} - 17'd1;
    assign new_end = {1'b0, addr_reg} + {9'd0, count_reg} - 17'd1;
    assign lookup_hit  = (addr_reg >= rd_data_reg.start) && ({1'b0, addr_reg} <= ent_end);
    assign overlap_hit = ({1'b0, addr_reg} <= ent_end) && ({1'b0, rd_data_reg.start} <= new_end);

    // Report status
    always_comb
    begin
        stat.is_lookup   = (req_type_reg == REQ_LOOKUP);
        stat.add_invalid = (addr_reg == 16'd0) || (count_reg == 8'd0);
        stat.add_full    = (used_reg == CNT_W'(TABLE_ENTRIES))
                        || (LIM_W'(used_reg) >= LIM_W'(max_entries_reg));
        stat.scan_more   = (idx_reg < used_reg);
        stat.cmp_pending = cmp_valid_reg;
        stat.cmp_hit     = cmp_valid_reg && (stat.is_lookup ? lookup_hit : overlap_hit);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Hold result until the output register is free
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            if (cmd.res_found)
            begin
                res_entry_reg <= rd_data_reg;
            end
            else
            begin
                res_entry_reg <= '0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_key_low  = out_entry_reg.key_low;
    assign found_key_high = out_entry_reg.key_high;
    assign found_start    = out_entry_reg.start;
    assign found_count    = out_entry_reg.count;

endmodule

`default_nettype wire
